>>> rtl/tkcs_pkg.sv
// Shared types and constants for the top-k count selector.
// Used by tkcs_ctrl, tkcs_datapath and top_k_count_selector_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tkcs_pkg;

    localparam int MATCH_W    = 16;
    localparam int IDX_W      = 10;
    localparam int RANK_CNT_W = 16;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [1:0] {
        S_COLLECT = 2'b01,
        S_DRAIN   = 2'b10
    } state_t;

    typedef struct packed {
        logic insert;
        logic end_set;
        logic pop;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/tkcs_datapath.sv
// Datapath of the top-k count selector: sorted list, candidate counter, result register.
// Depends on tkcs_pkg; driven by commands from tkcs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tkcs_datapath #(
    parameter int TOP_K      = 5,
    parameter int MAX_ITEMS  = 1024,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tkcs_pkg::cmd_t                  cmd,
    input  wire logic [tkcs_pkg::MATCH_W-1:0]    match_count,
    output logic      [tkcs_pkg::IDX_W-1:0]      rank_index,
    output logic      [tkcs_pkg::RANK_CNT_W-1:0] rank_count
);

    localparam int CW   = (COUNT_BITS < tkcs_pkg::MATCH_W) ? COUNT_BITS : tkcs_pkg::MATCH_W;
    localparam int CNTW = $clog2(MAX_ITEMS + 1);
    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int IW   = (AW < tkcs_pkg::IDX_W) ? AW : tkcs_pkg::IDX_W;
    localparam logic [CNTW-1:0] MAX_C = CNTW'(MAX_ITEMS);

    logic [CW-1:0]   cnt_reg  [TOP_K];
    logic [CW-1:0]   cnt_next [TOP_K];
    logic [IW-1:0]   idx_reg  [TOP_K];
    logic [IW-1:0]   idx_next [TOP_K];
    logic [CNTW-1:0] item_cnt_reg;
    logic [CNTW-1:0] item_cnt_next;
    logic [tkcs_pkg::IDX_W-1:0]      out_idx_reg;
    logic [tkcs_pkg::RANK_CNT_W-1:0] out_cnt_reg;

    logic [CW-1:0] new_cnt;
    logic [IW-1:0] new_idx;
    logic          room;
    logic [TOP_K-1:0] greater;
    logic [CW-1:0] ins_cnt [TOP_K];
    logic [IW-1:0] ins_idx [TOP_K];

    assign new_cnt = match_count[CW-1:0];
    assign new_idx = item_cnt_reg[IW-1:0];
    assign room    = (item_cnt_reg < MAX_C);

    // The list is held largest first, so the greater-than flags form a run up to the tail.
    genvar g;
    generate
        for (g = 0; g < TOP_K; g++) begin : g_slot
            assign greater[g] = (new_cnt > cnt_reg[g]);
            if (g == 0) begin : g_head
                assign ins_cnt[g] = greater[g] ? new_cnt : cnt_reg[g];
                assign ins_idx[g] = greater[g] ? new_idx : idx_reg[g];
            end else begin : g_body
                assign ins_cnt[g] = !greater[g] ? cnt_reg[g] :
                                    (greater[g-1] ? cnt_reg[g-1] : new_cnt);
                assign ins_idx[g] = !greater[g] ? idx_reg[g] :
                                    (greater[g-1] ? idx_reg[g-1] : new_idx);
            end
        end
    endgenerate

    always_comb
    begin
        item_cnt_next = item_cnt_reg;
        for (int i = 0; i < TOP_K; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            idx_next[i] = idx_reg[i];
        end
        if (cmd.insert && room)
        begin
            item_cnt_next = item_cnt_reg + CNTW'(1);
            for (int i = 0; i < TOP_K; i++)
            begin
                cnt_next[i] = ins_cnt[i];
                idx_next[i] = ins_idx[i];
            end
        end
        if (cmd.insert && cmd.end_set)
        begin
            item_cnt_next = '0;
        end
        // Popping moves every entry one place up and fills the tail with an empty slot,
        // so a full drain leaves the list cleared.
        if (cmd.pop)
        begin
            for (int i = 0; i < TOP_K - 1; i++)
            begin
                cnt_next[i] = cnt_reg[i+1];
                idx_next[i] = idx_reg[i+1];
            end
            cnt_next[TOP_K-1] = '0;
            idx_next[TOP_K-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_cnt_reg <= '0;
            for (int i = 0; i < TOP_K; i++)
            begin
                cnt_reg[i] <= '0;
                idx_reg[i] <= '0;
            end
        end
        else
        begin
            item_cnt_reg <= item_cnt_next;
            for (int i = 0; i < TOP_K; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
                idx_reg[i] <= idx_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_idx_reg <= tkcs_pkg::IDX_W'(idx_reg[0]);
            out_cnt_reg <= tkcs_pkg::RANK_CNT_W'(cnt_reg[0]);
        end
    end

    assign rank_index = out_idx_reg;
    assign rank_count = out_cnt_reg;

endmodule

`default_nettype wire

>>> rtl/tkcs_ctrl.sv
// Controller of the top-k count selector: collect and drain sequencing, output valid and last.
// Depends on tkcs_pkg; issues commands to tkcs_datapath.
`timescale 1ns / 1ps
`default_nettype none

module tkcs_ctrl #(
    parameter int TOP_K = 5
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_last,
    output logic                in_ready,
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic                out_last,
    output tkcs_pkg::cmd_t      cmd
);

    localparam int RW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam logic [RW-1:0] LAST_RANK = RW'(TOP_K - 1);

    tkcs_pkg::state_t state_reg, state_next;
    logic [RW-1:0]    rank_reg, rank_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;
    logic             accept;
    logic             pop;

    assign in_ready = (state_reg == tkcs_pkg::S_COLLECT);
    assign accept   = in_valid && in_ready;
    assign pop      = (state_reg == tkcs_pkg::S_DRAIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        rank_next      = rank_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            tkcs_pkg::S_COLLECT:
            begin
                if (accept && in_last)
                begin
                    state_next = tkcs_pkg::S_DRAIN;
                    rank_next  = '0;
                end
            end
            tkcs_pkg::S_DRAIN:
            begin
                if (pop)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = (rank_reg == LAST_RANK);
                    rank_next      = rank_reg + RW'(1);
                    if (rank_reg == LAST_RANK)
                    begin
                        state_next = tkcs_pkg::S_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = tkcs_pkg::S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkcs_pkg::S_COLLECT;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign cmd.insert  = accept;
    assign cmd.end_set = in_last;
    assign cmd.pop     = pop;
    assign out_valid   = out_valid_reg;
    assign out_last    = out_last_reg;

    a_close_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> !in_ready)
        else $error("input still ready after the closing beat of a set");

    a_final_rank_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && rank_reg == LAST_RANK) |=> (out_valid && out_last && in_ready))
        else $error("final rank not flagged last or input not reopened");

    a_drain_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tkcs_pkg::S_DRAIN && rank_reg != '0) |-> out_valid_reg)
        else $error("output valid dropped in the middle of a drain");

    a_no_pop_while_collect: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.pop)
        else $error("list popped while collecting");

endmodule

`default_nettype wire

>>> rtl/top_k_count_selector_core.sv
// Top level of the top-k count selector: stream ports around controller and datapath.
// Depends on tkcs_pkg, tkcs_ctrl and tkcs_datapath.
//
//  Channel  | Dir | Beat contents
//  ---------+-----+-------------------------------------------------------------
//  s_*      | in  | one candidate count; tlast closes the set
//  m_*      | out | one rank, best first; tlast on rank TOP_K-1
//
// While a set is being collected one beat is taken every cycle.
// The beat that closes a set is followed by TOP_K result beats, one per cycle when
// m_tready is high; s_tready stays low until the drain sequencer has issued the last of them.
// The next set may start in the cycle after the final result is loaded into the output register.
// Reset clears the list and the candidate counter at once, with no clearing pass.
// A stalled output holds its beat and pauses the drain.
`timescale 1ns / 1ps
`default_nettype none

module top_k_count_selector_core #(
    parameter int TOP_K      = 5,
    parameter int MAX_ITEMS  = 1024,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [tkcs_pkg::IN_TDATA_W-1:0]     s_tdata,  // [15:0] match_count
    input  wire logic                                s_tlast,  // end_of_set
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [tkcs_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [9:0] rank_index, [25:10] rank_count
    output logic                                     m_tlast   // last_rank
);

    tkcs_pkg::cmd_t                  cmd;
    logic [tkcs_pkg::IDX_W-1:0]      rank_index;
    logic [tkcs_pkg::RANK_CNT_W-1:0] rank_count;

    tkcs_ctrl #(
        .TOP_K (TOP_K)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_last  (m_tlast),
        .cmd       (cmd)
    );

    tkcs_datapath #(
        .TOP_K      (TOP_K),
        .MAX_ITEMS  (MAX_ITEMS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .match_count (s_tdata[tkcs_pkg::MATCH_W-1:0]),
        .rank_index  (rank_index),
        .rank_count  (rank_count)
    );

    assign m_tdata = {{(tkcs_pkg::OUT_TDATA_W - tkcs_pkg::RANK_CNT_W - tkcs_pkg::IDX_W){1'b0}},
                      rank_count, rank_index};

endmodule

`default_nettype wire
